### design/segx_pkg.sv
package segx_pkg;

  // the two coordinate axes handled side by side in the divider
  localparam int unsigned NUM_AXES = 2;
  localparam int unsigned AX_X     = 0;
  localparam int unsigned AX_Y     = 1;

endpackage

### design/segx_in_if.sv
interface segx_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

### design/segx_out_if.sv
interface segx_out_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [COORD_BITS-1:0] cross_x;
  logic signed [COORD_BITS-1:0] cross_y;

  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

### design/segx_front.sv
module segx_front import segx_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic signed [W-1:0]  x1,
  input  logic signed [W-1:0]  y1,
  input  logic signed [W-1:0]  x2,
  input  logic signed [W-1:0]  y2,
  input  logic signed [W-1:0]  x3,
  input  logic signed [W-1:0]  y3,
  input  logic signed [W-1:0]  x4,
  input  logic signed [W-1:0]  y4,
  output logic                 vld_out,
  output logic                 hit,
  output logic [2*W+2:0]       det_mag,
  output logic [2*W+2:0]       sn_pos,
  output logic signed [W-1:0]  x4_out,
  output logic signed [W-1:0]  y4_out,
  output logic signed [W:0]    dx34_out,
  output logic signed [W:0]    dy34_out
);

  localparam int unsigned D = W + 1;
  localparam int unsigned P = 2 * D;
  localparam int unsigned C = P + 1;

  // stage 1: differences
  logic                vld1_r;
  logic signed [D-1:0] dx12_r, dy12_r, dx34_r, dy34_r, dx24_r, dy24_r;
  logic signed [W-1:0] x4a_r, y4a_r;
  logic signed [D-1:0] dx12_nxt, dy12_nxt, dx34_nxt, dy34_nxt, dx24_nxt, dy24_nxt;

  assign dx12_nxt = x1 - x2;
  assign dy12_nxt = y1 - y2;
  assign dx34_nxt = x3 - x4;
  assign dy34_nxt = y3 - y4;
  assign dx24_nxt = x2 - x4;
  assign dy24_nxt = y2 - y4;

  // stage 2: six products
  logic                vld2_r;
  logic signed [P-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [P-1:0] m0_nxt, m1_nxt, m2_nxt, m3_nxt, m4_nxt, m5_nxt;
  logic signed [W-1:0] x4b_r, y4b_r;
  logic signed [D-1:0] dx34b_r, dy34b_r;

  assign m0_nxt = dx12_r * dy34_r;
  assign m1_nxt = dy12_r * dx34_r;
  assign m2_nxt = dx12_r * dy24_r;
  assign m3_nxt = dy12_r * dx24_r;
  assign m4_nxt = dx34_r * dy24_r;
  assign m5_nxt = dy34_r * dx24_r;

  // stage 3: determinant and numerators
  logic                vld3_r;
  logic signed [C-1:0] det_r, sn_r, tn_r;
  logic signed [C-1:0] det_nxt, sn_nxt, tn_nxt;
  logic signed [W-1:0] x4c_r, y4c_r;
  logic signed [D-1:0] dx34c_r, dy34c_r;

  assign det_nxt = m0_r - m1_r;
  assign sn_nxt  = m2_r - m3_r;
  assign tn_nxt  = m4_r - m5_r;

  // stage 4: sign normalize and range test
  logic                vld4_r, hit4_r;
  logic [C-1:0]        detm4_r, sn4_r;
  logic signed [W-1:0] x4d_r, y4d_r;
  logic signed [D-1:0] dx34d_r, dy34d_r;
  logic signed [C:0]   detm_nxt, snv_nxt, tnv_nxt;
  logic                hit_nxt;

  always_comb begin
    if (det_r[C-1]) begin
      detm_nxt = -(C+1)'(det_r);
      snv_nxt  = -(C+1)'(sn_r);
      tnv_nxt  = -(C+1)'(tn_r);
    end else begin
      detm_nxt = (C+1)'(det_r);
      snv_nxt  = (C+1)'(sn_r);
      tnv_nxt  = (C+1)'(tn_r);
    end
    hit_nxt = (det_r != '0) && !snv_nxt[C] && !tnv_nxt[C] &&
              (snv_nxt <= detm_nxt) && (tnv_nxt <= detm_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx12_r  <= dx12_nxt;
      dy12_r  <= dy12_nxt;
      dx34_r  <= dx34_nxt;
      dy34_r  <= dy34_nxt;
      dx24_r  <= dx24_nxt;
      dy24_r  <= dy24_nxt;
      x4a_r   <= x4;
      y4a_r   <= y4;
      m0_r    <= m0_nxt;
      m1_r    <= m1_nxt;
      m2_r    <= m2_nxt;
      m3_r    <= m3_nxt;
      m4_r    <= m4_nxt;
      m5_r    <= m5_nxt;
      x4b_r   <= x4a_r;
      y4b_r   <= y4a_r;
      dx34b_r <= dx34_r;
      dy34b_r <= dy34_r;
      det_r   <= det_nxt;
      sn_r    <= sn_nxt;
      tn_r    <= tn_nxt;
      x4c_r   <= x4b_r;
      y4c_r   <= y4b_r;
      dx34c_r <= dx34b_r;
      dy34c_r <= dy34b_r;
      hit4_r  <= hit_nxt;
      detm4_r <= detm_nxt[C-1:0];
      sn4_r   <= snv_nxt[C-1:0];
      x4d_r   <= x4c_r;
      y4d_r   <= y4c_r;
      dx34d_r <= dx34c_r;
      dy34d_r <= dy34c_r;
    end
  end

  assign vld_out  = vld4_r;
  assign hit      = hit4_r;
  assign det_mag  = detm4_r;
  assign sn_pos   = sn4_r;
  assign x4_out   = x4d_r;
  assign y4_out   = y4d_r;
  assign dx34_out = dx34d_r;
  assign dy34_out = dy34d_r;

endmodule

### design/segx_div.sv
module segx_div import segx_pkg::*; #(
  parameter int unsigned W  = 16,
  parameter int unsigned C  = 2 * W + 3,
  parameter int unsigned NM = 3 * W + 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  logic                tag_in,
  input  logic [C-1:0]        den,
  input  logic                neg [NUM_AXES],
  input  logic [NM-1:0]       mag [NUM_AXES],
  output logic                vld_out,
  output logic                tag_out,
  output logic signed [W-1:0] res [NUM_AXES]
);

  // quotient magnitude stays below 2^Q
  localparam int unsigned Q = W + 1;

  logic [C-1:0] rem_r [Q][NUM_AXES];
  logic [Q-1:0] low_r [Q][NUM_AXES];
  logic [Q-1:0] q_r   [Q][NUM_AXES];
  logic         neg_r [Q][NUM_AXES];
  logic [C-1:0] den_r [Q];
  logic         tag_r [Q];
  logic         vld_r [Q];

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [C-1:0] rem_src [NUM_AXES];
    logic [Q-1:0] low_src [NUM_AXES];
    logic [Q-1:0] q_src   [NUM_AXES];
    logic         neg_src [NUM_AXES];
    logic [C-1:0] den_src;
    logic         tag_src, vld_src;
    logic [C-1:0] rem_nxt [NUM_AXES];
    logic [Q-1:0] q_nxt   [NUM_AXES];

    if (k == 0) begin : g_first
      for (genvar a = 0; a < NUM_AXES; a++) begin : g_ax
        assign rem_src[a] = C'(mag[a] >> Q);
        assign low_src[a] = mag[a][Q-1:0];
        assign q_src[a]   = '0;
        assign neg_src[a] = neg[a];
      end
      assign den_src = den;
      assign tag_src = tag_in;
      assign vld_src = vld_in;
    end else begin : g_next
      for (genvar a = 0; a < NUM_AXES; a++) begin : g_ax
        assign rem_src[a] = rem_r[k-1][a];
        assign low_src[a] = low_r[k-1][a];
        assign q_src[a]   = q_r[k-1][a];
        assign neg_src[a] = neg_r[k-1][a];
      end
      assign den_src = den_r[k-1];
      assign tag_src = tag_r[k-1];
      assign vld_src = vld_r[k-1];
    end

    always_comb begin
      logic [C:0]   shifted;
      logic [C+1:0] trial;
      for (int a = 0; a < NUM_AXES; a++) begin
        shifted    = {rem_src[a], low_src[a][Q-1-k]};
        trial      = {1'b0, shifted} - {2'b00, den_src};
        rem_nxt[a] = trial[C+1] ? shifted[C-1:0] : trial[C-1:0];
        q_nxt[a]   = {q_src[a][Q-2:0], !trial[C+1]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          rem_r[k][a] <= rem_nxt[a];
          low_r[k][a] <= low_src[a];
          q_r[k][a]   <= q_nxt[a];
          neg_r[k][a] <= neg_src[a];
        end
        den_r[k] <= den_src;
        tag_r[k] <= tag_src;
      end
    end
  end

  // round half away from zero, then apply the sign; a miss gives zero
  logic signed [W-1:0] res_r   [NUM_AXES];
  logic signed [W-1:0] res_nxt [NUM_AXES];
  logic                vld_o_r, tag_o_r;

  always_comb begin
    logic         up;
    logic [Q-1:0] qr;
    for (int a = 0; a < NUM_AXES; a++) begin
      up = {rem_r[Q-1][a], 1'b0} >= {1'b0, den_r[Q-1]};
      qr = q_r[Q-1][a] + Q'(up);
      if (!tag_r[Q-1]) begin
        res_nxt[a] = '0;
      end else if (neg_r[Q-1][a]) begin
        res_nxt[a] = W'(-qr);
      end else begin
        res_nxt[a] = W'(qr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else if (en) begin
      vld_o_r <= vld_r[Q-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_o_r <= tag_r[Q-1];
      for (int a = 0; a < NUM_AXES; a++) begin
        res_r[a] <= res_nxt[a];
      end
    end
  end

  assign vld_out = vld_o_r;
  assign tag_out = tag_o_r;
  assign res     = res_r;

endmodule

### design/segment_intersection.sv
// channel | dir | handshake        | beat contents
// in_if   | in  | valid / ready    | a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y
// out_if  | out | valid / ready    | hit, cross_x, cross_y
//
// one beat in and one beat out per cycle while out_if is not stalled
// (four geometry stages, three numerator stages, one restoring divider
// stage per quotient bit, one rounding and output stage)
// synchronous active-low reset clears the valid bits only
// a stall on out_if freezes the whole pipeline and drops in_if.ready
module segment_intersection import segx_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  segx_in_if.sink   in_if,
  segx_out_if.source out_if
);

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned D  = W + 1;
  localparam int unsigned C  = 2 * D + 1;
  localparam int unsigned NW = D + C + 2;

  logic en;
  logic div_vld, div_tag;

  assign en          = out_if.ready || !div_vld;
  assign in_if.ready = en;

  logic                f_vld, f_hit;
  logic [C-1:0]        f_det, f_sn;
  logic signed [W-1:0] f_x4, f_y4;
  logic signed [D-1:0] f_dx34, f_dy34;

  segx_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (in_if.valid),
    .x1       (in_if.a_start_x),
    .y1       (in_if.a_start_y),
    .x2       (in_if.a_end_x),
    .y2       (in_if.a_end_y),
    .x3       (in_if.b_start_x),
    .y3       (in_if.b_start_y),
    .x4       (in_if.b_end_x),
    .y4       (in_if.b_end_y),
    .vld_out  (f_vld),
    .hit      (f_hit),
    .det_mag  (f_det),
    .sn_pos   (f_sn),
    .x4_out   (f_x4),
    .y4_out   (f_y4),
    .dx34_out (f_dx34),
    .dy34_out (f_dy34)
  );

  // numerator P4*det + (P3-P4)*sn for both axes
  logic                vld5_r, hit5_r;
  logic [C-1:0]        det5_r;
  logic signed [NW-1:0] px_r, py_r, sx_r, sy_r;
  logic signed [NW-1:0] px_nxt, py_nxt, sx_nxt, sy_nxt;

  assign px_nxt = f_x4 * $signed({1'b0, f_det});
  assign py_nxt = f_y4 * $signed({1'b0, f_det});
  assign sx_nxt = f_dx34 * $signed({1'b0, f_sn});
  assign sy_nxt = f_dy34 * $signed({1'b0, f_sn});

  logic                 vld6_r, hit6_r;
  logic [C-1:0]         det6_r;
  logic signed [NW-1:0] nx_r, ny_r;

  logic                 vld7_r, hit7_r;
  logic [C-1:0]         det7_r;
  logic [NW-1:0]        mag_r [NUM_AXES];
  logic                 neg_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else if (en) begin
      vld5_r <= f_vld;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit5_r <= f_hit;
      det5_r <= f_det;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      hit6_r <= hit5_r;
      det6_r <= det5_r;
      nx_r   <= px_r + sx_r;
      ny_r   <= py_r + sy_r;
      hit7_r <= hit6_r;
      det7_r <= det6_r;
      neg_r[AX_X] <= nx_r[NW-1];
      neg_r[AX_Y] <= ny_r[NW-1];
      mag_r[AX_X] <= nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
      mag_r[AX_Y] <= ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
    end
  end

  logic signed [W-1:0] res [NUM_AXES];

  segx_div #(.W(W), .C(C), .NM(NW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (vld7_r),
    .tag_in  (hit7_r),
    .den     (det7_r),
    .neg     (neg_r),
    .mag     (mag_r),
    .vld_out (div_vld),
    .tag_out (div_tag),
    .res     (res)
  );

  assign out_if.valid   = div_vld;
  assign out_if.hit     = div_tag;
  assign out_if.cross_x = res[AX_X];
  assign out_if.cross_y = res[AX_Y];

endmodule

### design/segx_chk.sv
module segx_chk #(
  parameter int unsigned W = 16
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic         hit,
  input logic [W-1:0] cross_x,
  input logic [W-1:0] cross_y
);

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !hit) |-> (cross_x == '0 && cross_y == '0))
    else $error("miss beat with nonzero point");

  // input side only stalls behind a held result
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(hit) && $stable(cross_x) && $stable(cross_y)))
    else $error("result changed under stall");

endmodule

bind segment_intersection segx_chk #(.W(COORD_BITS)) u_segx_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .hit       (out_if.hit),
  .cross_x   (out_if.cross_x),
  .cross_y   (out_if.cross_y)
);

### tb/segx_checker.sv
module segx_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  segx_in_if.sink    in_mon,
  segx_out_if.sink   out_mon,
  output int         fail_count,
  output int         pending
);

  typedef struct {
    logic                         hit;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } crossing_t;

  crossing_t crossings_due[$];

  // rounded quotient, ties away from zero; den > 0
  function automatic logic signed [COORD_BITS-1:0] div_round(logic signed [127:0] num,
                                                             logic signed [127:0] den);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    logic signed [127:0] r;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    r = mag % den;
    if (2 * r >= den) q = q + 1;
    if (num < 0) q = -q;
    return q[COORD_BITS-1:0];
  endfunction

  function automatic crossing_t find_crossing(
      logic signed [COORD_BITS-1:0] x1, logic signed [COORD_BITS-1:0] y1,
      logic signed [COORD_BITS-1:0] x2, logic signed [COORD_BITS-1:0] y2,
      logic signed [COORD_BITS-1:0] x3, logic signed [COORD_BITS-1:0] y3,
      logic signed [COORD_BITS-1:0] x4, logic signed [COORD_BITS-1:0] y4);
    logic signed [127:0] dx12, dy12, dx34, dy34, dx24, dy24, det, sn, tn;
    crossing_t res;
    dx12 = 128'(x1) - 128'(x2);
    dy12 = 128'(y1) - 128'(y2);
    dx34 = 128'(x3) - 128'(x4);
    dy34 = 128'(y3) - 128'(y4);
    dx24 = 128'(x2) - 128'(x4);
    dy24 = 128'(y2) - 128'(y4);
    det = dx12 * dy34 - dy12 * dx34;
    sn = dx12 * dy24 - dy12 * dx24;
    tn = dx34 * dy24 - dy34 * dx24;
    res.hit = 1'b0;
    res.cx = '0;
    res.cy = '0;
    if (det == 0) return res;
    if (det < 0) begin
      det = -det;
      sn = -sn;
      tn = -tn;
    end
    if (sn < 0 || tn < 0 || sn > det || tn > det) return res;
    res.hit = 1'b1;
    res.cx = div_round(128'(x4) * det + dx34 * sn, det);
    res.cy = div_round(128'(y4) * det + dy34 * sn, det);
    return res;
  endfunction

  assign pending = crossings_due.size();

  always @(posedge clk) begin
    crossing_t exp_c;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        crossings_due.push_back(find_crossing(in_mon.a_start_x, in_mon.a_start_y,
            in_mon.a_end_x, in_mon.a_end_y, in_mon.b_start_x, in_mon.b_start_y,
            in_mon.b_end_x, in_mon.b_end_y));
      if (out_mon.valid && out_mon.ready) begin
        if (crossings_due.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_c = crossings_due.pop_front();
          if (out_mon.hit !== exp_c.hit) begin
            $error("hit: expected %0d, got %0d", exp_c.hit, out_mon.hit);
            fail_count <= fail_count + 1;
          end else if (out_mon.cross_x !== exp_c.cx) begin
            $error("cross_x: expected %0d, got %0d", exp_c.cx, out_mon.cross_x);
            fail_count <= fail_count + 1;
          end else if (out_mon.cross_y !== exp_c.cy) begin
            $error("cross_y: expected %0d, got %0d", exp_c.cy, out_mon.cross_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### tb/segment_intersection_tb.sv
module segment_intersection_tb;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned LATENCY    = COORD_BITS + 9;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_pct = 0;
  int   stall_pct = 0;

  segx_in_if  #(.COORD_BITS(COORD_BITS)) in_if ();
  segx_out_if #(.COORD_BITS(COORD_BITS)) out_if ();

  segment_intersection #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  segx_checker #(.COORD_BITS(COORD_BITS)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if.sink),
    .out_mon    (out_if.sink),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    {in_if.a_start_x, in_if.a_start_y, in_if.a_end_x, in_if.a_end_y} = '0;
    {in_if.b_start_x, in_if.b_start_y, in_if.b_end_x, in_if.b_end_y} = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk)
    out_if.ready <= ($urandom_range(99) >= stall_pct);

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom());
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  // one beat: wait out sender idle, hold until accepted
  task automatic send_beat(coord_t p[8]);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.a_start_x <= p[0];
    in_if.a_start_y <= p[1];
    in_if.a_end_x   <= p[2];
    in_if.a_end_y   <= p[3];
    in_if.b_start_x <= p[4];
    in_if.b_start_y <= p[5];
    in_if.b_end_x   <= p[6];
    in_if.b_end_y   <= p[7];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_random(int count);
    coord_t p[8];
    int span;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      span = (kind < 3) ? 0 : (kind < 6) ? 2000 : (kind < 8) ? 64 : 8;
      foreach (p[k]) p[k] = rand_coord(span);
      if (kind == 9) begin
        // shared end point, or b_start on A's line past a_end
        if ($urandom_range(1)) begin
          p[4] = p[2];
          p[5] = p[3];
        end else begin
          p[4] = coord_t'(p[0] + (p[2] - p[0]) * 2);
          p[5] = coord_t'(p[1] + (p[3] - p[1]) * 2);
        end
      end
      send_beat(p);
    end
  endtask

  initial begin
    coord_t p[8];
    int wait_cycles;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    p = '{-160, 0, 160, 0, 0, -160, 0, 160};         send_beat(p);  // plain cross
    p = '{0, 0, 160, 160, 0, 160, 160, 0};           send_beat(p);  // diagonals
    p = '{0, 0, 160, 0, 0, 16, 160, 16};             send_beat(p);  // parallel
    p = '{0, 0, 160, 0, 32, 0, 320, 0};              send_beat(p);  // collinear
    p = '{5, 5, 5, 5, 0, 0, 16, 16};                 send_beat(p);  // degenerate
    p = '{0, 0, 160, 0, 80, 16, 80, 160};            send_beat(p);  // misses
    p = '{0, 0, 160, 0, 160, 0, 160, 160};           send_beat(p);  // touches at end
    p = '{0, 0, 160, 0, 80, 0, 80, 160};             send_beat(p);  // b_start on A
    p = '{0, 0, 3, 1, 0, 1, 3, 0};                   send_beat(p);  // half units
    p = '{0, 0, -3, -1, 0, -1, -3, 0};               send_beat(p);
    p = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}; send_beat(p);
    p = '{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768}; send_beat(p);
    p = '{-32768, 0, 32767, 0, 0, -32768, 0, 32767}; send_beat(p);
    p = '{-1, -1, -1, -1, -1, -1, -1, -1};           send_beat(p);
    p = '{32767, 32767, -32768, -32768, 1, 0, 0, 1}; send_beat(p);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 19 : 65) : 0;
      stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 19 : 65) : 0;
      send_random(320);
      if (phase == 0) begin
        idle_pct = 0;
        stall_pct = 0;
      end
    end
    in_if.valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
